// File: hw/rtl/fsih_pkg.sv
// Shared constants, log-curve functions and store interface types for the flow histogram.
package fsih_pkg;

	localparam int INTERVAL_BINS          = 32;
	localparam int SIZE_BINS              = 32;
	localparam int INTERVAL_LIMIT_SECONDS = 600;
	localparam int TOTAL_BINS             = INTERVAL_BINS + SIZE_BINS;

	localparam int IDX_W  = $clog2(TOTAL_BINS);
	localparam int GBIN_W = $clog2(INTERVAL_BINS);
	localparam int SBIN_W = $clog2(SIZE_BINS);

	localparam int FLOW_W   = 32;
	localparam int SEC_W    = 32;
	localparam int USEC_W   = 20;
	localparam int SIZE_W   = 16;
	localparam int LABEL_W  = 33;
	localparam int COLUMN_W = 7;
	localparam int COUNT_W  = 32;

	// Arrival time in microseconds never reaches 2^52.
	localparam int TIME_W = 52;

	// Mantissa of the log unit: Q30 value kept in a 32-bit register.
	localparam int MAN_W     = 32;
	localparam int MAN_POINT = 30;
	localparam int LG_FRAC   = 24;
	localparam int LG_INT_W  = 5;
	localparam int LG_W      = LG_INT_W + LG_FRAC;

	localparam logic [MAN_W-1:0]  USEC_PER_SEC   = 32'd1000000;
	localparam logic [MAN_W-1:0]  EXP_Q32        = 32'd1550712125;
	localparam logic [63:0]       LIMIT_US       = 64'(INTERVAL_LIMIT_SECONDS) * 64'd1000000;
	localparam logic [SIZE_W-1:0] SIZE_MIN_RESET = 16'd24;

	// Base-2 logarithm in Q24, computed by repeated squaring of the mantissa.
	function automatic logic [63:0] lg_q24(input logic [63:0] n);
		logic [63:0] m;
		logic [63:0] r;
		int          p;
		p = 0;
		for (int b = 0; b < 64; b++) begin
			if (n[b]) p = b;
		end
		if (n == 64'd0) return 64'd0;
		if (p >= 30) m = n >> (p - 30);
		else m = n << (30 - p);
		r = 64'(p) << 24;
		for (int i = 23; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	// Scaled log distance of gap bin j from the top of the curve; zero disables the bin.
	function automatic logic [63:0] gap_thresh(input int j);
		logic [63:0] ld;
		logic [63:0] lj;
		ld = lg_q24(64'(INTERVAL_BINS));
		lj = lg_q24(64'(j));
		return (ld > lj) ? ((ld - lj) << 32) : 64'd0;
	endfunction

	localparam logic [63:0] LG_LIMIT = lg_q24(LIMIT_US);

	typedef struct packed {
		logic             rd_en;
		logic             bump_en;
		logic             drop_en;
		logic [IDX_W-1:0] addr;
	} bin_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               last;
		logic               hit;
		logic               empty;
	} bin_rsp_t;

endpackage

// File: hw/rtl/flow_size_interval_histogram.sv
// Per-flow histogram of packet inter-arrival gaps and sizes, flushed as nonzero bins.
//
// One input beat is taken at a time; in_ready is low while it is processed. A packet of
// the running flow passes the time, gap and class steps, the normalize steps of the gap,
// 24 squaring steps of the log unit, the exponent scaling and INTERVAL_BINS-1 threshold
// compares, then a read and a bump of its gap bin and of its size bin; the single shared
// 32x32 multiplier serves these steps in turn, and the threshold scan makes one compare
// per cycle. A gap of zero or beyond the limit skips the log unit, and the first packet of
// a flow only bumps its size bin. A flush, caused by a flow change or an end beat, reads
// the bins in order, emits one beat per nonzero bin and waits while out_ready stalls the
// output register.
// Results sit in an output register, so the next input beat is taken while the last one
// waits. Reset clears the row at once; there is no clearing pass.
module flow_size_interval_histogram (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fsih_pkg::SIZE_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [fsih_pkg::FLOW_W-1:0]    flow_id,
	input  logic [fsih_pkg::SEC_W-1:0]     seconds,
	input  logic [fsih_pkg::USEC_W-1:0]    microseconds,
	input  logic [fsih_pkg::SIZE_W-1:0]    packet_size,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fsih_pkg::LABEL_W-1:0]   flow_label,
	output logic [fsih_pkg::COLUMN_W-1:0]  column,
	output logic [fsih_pkg::COUNT_W-1:0]   bin_count,
	output logic                           last
);
	import fsih_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TIME,
		S_GAP,
		S_CLASS,
		S_NORM,
		S_SQR,
		S_LHS,
		S_SCAN,
		S_BUMP_RD,
		S_BUMP_WR,
		S_FL_RD,
		S_FL_EMIT
	} state_t;

	state_t              state_q;
	logic [SIZE_W-1:0]   size_min_q;
	logic [FLOW_W-1:0]   flow_q;
	logic [SEC_W-1:0]    sec_q;
	logic [USEC_W-1:0]   usec_q;
	logic [SIZE_W-1:0]   size_q;
	logic [FLOW_W-1:0]   cur_flow_q;
	logic                row_active_q;
	logic [TIME_W-1:0]   prev_time_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   gap_q;
	logic                pkt_pend_q;
	logic                size_phase_q;
	logic [IDX_W-1:0]    bin_idx_q;
	logic [GBIN_W-1:0]   j_q;
	logic [MAN_W-1:0]    m_q;
	logic [LG_INT_W-1:0] p_q;
	logic [LG_FRAC-1:0]  frac_q;
	logic [LG_INT_W-1:0] iter_q;
	logic [2*MAN_W-1:0]  lhs_q;

	logic                out_valid_q;
	logic [LABEL_W-1:0]  flow_label_q;
	logic [COLUMN_W-1:0] column_q;
	logic [COUNT_W-1:0]  bin_count_q;
	logic                last_q;

	logic [MAN_W-1:0]    mul_a;
	logic [MAN_W-1:0]    mul_b;
	logic [2*MAN_W-1:0]  mul_p;
	logic [MAN_W-1:0]    sq;
	logic [LG_W-1:0]     lg_diff;
	logic [SIZE_W-1:0]   size_diff;
	logic [SBIN_W-1:0]   sbin;
	logic [IDX_W-1:0]    size_idx;
	logic                emit_go;
	logic                out_take;
	logic [2*MAN_W-1:0]  thresh_tab [INTERVAL_BINS];

	bin_req_t            req;
	bin_rsp_t            rsp;

	fsih_bin_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	for (genvar j = 0; j < INTERVAL_BINS; j++) begin : g_thresh
		localparam logic [2*MAN_W-1:0] TH = gap_thresh(j);
		assign thresh_tab[j] = TH;
	end

	// The one multiplier serves the arrival time, the log squaring and the exponent scaling.
	always_comb begin
		case (state_q)
			S_TIME: begin
				mul_a = sec_q;
				mul_b = USEC_PER_SEC;
			end
			S_SQR: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			S_LHS: begin
				mul_a = MAN_W'(lg_diff);
				mul_b = EXP_Q32;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign sq      = mul_p[MAN_POINT+MAN_W-1:MAN_POINT];
	assign lg_diff = LG_LIMIT[LG_W-1:0] - {p_q, frac_q};

	// Sizes under the minimum fall into the lowest bin instead of wrapping.
	assign size_diff = size_q - size_min_q;
	always_comb begin
		if (size_q < size_min_q) sbin = '0;
		else if (size_diff > SIZE_W'(SIZE_BINS - 1)) sbin = SBIN_W'(SIZE_BINS - 1);
		else sbin = size_diff[SBIN_W-1:0];
	end
	assign size_idx = IDX_W'(INTERVAL_BINS) + IDX_W'(sbin);

	assign emit_go  = (state_q == S_FL_EMIT) && (!out_valid_q || out_ready);
	assign out_take = out_valid_q && out_ready;

	always_comb begin
		req         = '0;
		req.addr    = bin_idx_q;
		req.rd_en   = (state_q == S_BUMP_RD) || (state_q == S_FL_RD);
		req.bump_en = (state_q == S_BUMP_WR);
		req.drop_en = emit_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			size_min_q   <= SIZE_MIN_RESET;
			flow_q       <= '0;
			sec_q        <= '0;
			usec_q       <= '0;
			size_q       <= '0;
			cur_flow_q   <= '0;
			row_active_q <= 1'b0;
			prev_time_q  <= '0;
			now_q        <= '0;
			gap_q        <= '0;
			pkt_pend_q   <= 1'b0;
			size_phase_q <= 1'b0;
			bin_idx_q    <= '0;
			j_q          <= '0;
			m_q          <= '0;
			p_q          <= '0;
			frac_q       <= '0;
			iter_q       <= '0;
			lhs_q        <= '0;
			out_valid_q  <= 1'b0;
			flow_label_q <= '0;
			column_q     <= '0;
			bin_count_q  <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_we) size_min_q <= cfg_wdata;

			if (emit_go) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						flow_q <= flow_id;
						sec_q  <= seconds;
						usec_q <= microseconds;
						size_q <= packet_size;
						if (!action) begin
							state_q <= S_TIME;
						end else if (row_active_q) begin
							bin_idx_q  <= '0;
							pkt_pend_q <= 1'b0;
							state_q    <= S_FL_RD;
						end
					end
				end
				S_TIME: begin
					now_q <= mul_p[TIME_W-1:0] + TIME_W'(usec_q);
					if (row_active_q && flow_q == cur_flow_q) begin
						state_q <= S_GAP;
					end else if (row_active_q) begin
						bin_idx_q  <= '0;
						pkt_pend_q <= 1'b1;
						state_q    <= S_FL_RD;
					end else begin
						bin_idx_q    <= size_idx;
						size_phase_q <= 1'b1;
						state_q      <= S_BUMP_RD;
					end
				end
				S_GAP: begin
					gap_q   <= (now_q > prev_time_q) ? now_q - prev_time_q : '0;
					state_q <= S_CLASS;
				end
				S_CLASS: begin
					size_phase_q <= 1'b0;
					if (gap_q == '0) begin
						bin_idx_q <= '0;
						state_q   <= S_BUMP_RD;
					end else if (gap_q > TIME_W'(LIMIT_US)) begin
						bin_idx_q <= IDX_W'(INTERVAL_BINS - 1);
						state_q   <= S_BUMP_RD;
					end else begin
						m_q     <= MAN_W'(gap_q);
						p_q     <= LG_INT_W'(MAN_POINT);
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					// Bring the leading one to the Q30 point, tracking its position.
					if (m_q[MAN_W-1]) begin
						m_q <= m_q >> 1;
						p_q <= p_q + LG_INT_W'(1);
					end else if (!m_q[MAN_POINT]) begin
						m_q <= m_q << 1;
						p_q <= p_q - LG_INT_W'(1);
					end else begin
						frac_q  <= '0;
						iter_q  <= LG_INT_W'(LG_FRAC - 1);
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					// Each squaring yields one fraction bit of the logarithm, top bit first.
					m_q    <= sq[MAN_W-1] ? {1'b0, sq[MAN_W-1:1]} : sq;
					frac_q <= {frac_q[LG_FRAC-2:0], sq[MAN_W-1]};
					if (iter_q == '0) state_q <= S_LHS;
					else iter_q <= iter_q - LG_INT_W'(1);
				end
				S_LHS: begin
					lhs_q     <= mul_p;
					bin_idx_q <= '0;
					j_q       <= GBIN_W'(1);
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (lhs_q < thresh_tab[j_q]) bin_idx_q <= bin_idx_q + IDX_W'(1);
					if (j_q == GBIN_W'(INTERVAL_BINS - 1)) state_q <= S_BUMP_RD;
					else j_q <= j_q + GBIN_W'(1);
				end
				S_BUMP_RD: begin
					state_q <= S_BUMP_WR;
				end
				S_BUMP_WR: begin
					if (!size_phase_q) begin
						bin_idx_q    <= size_idx;
						size_phase_q <= 1'b1;
						state_q      <= S_BUMP_RD;
					end else begin
						cur_flow_q   <= flow_q;
						prev_time_q  <= now_q;
						row_active_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_FL_RD: begin
					if (rsp.empty) begin
						row_active_q <= 1'b0;
						if (pkt_pend_q) begin
							bin_idx_q    <= size_idx;
							size_phase_q <= 1'b1;
							state_q      <= S_BUMP_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (rsp.hit) begin
						state_q <= S_FL_EMIT;
					end else begin
						bin_idx_q <= bin_idx_q + IDX_W'(1);
					end
				end
				S_FL_EMIT: begin
					if (emit_go) begin
						flow_label_q <= LABEL_W'(cur_flow_q) + LABEL_W'(1);
						column_q     <= COLUMN_W'(bin_idx_q) + COLUMN_W'(1);
						bin_count_q  <= rsp.count;
						last_q       <= rsp.last;
						if (rsp.last) begin
							row_active_q <= 1'b0;
							if (pkt_pend_q) begin
								bin_idx_q    <= size_idx;
								size_phase_q <= 1'b1;
								state_q      <= S_BUMP_RD;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							bin_idx_q <= bin_idx_q + IDX_W'(1);
							state_q   <= S_FL_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign flow_label = flow_label_q;
	assign column     = column_q;
	assign bin_count  = bin_count_q;
	assign last       = last_q;

	// Finishing a packet always leaves a flow running.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUMP_WR && size_phase_q) |=> (row_active_q && state_q == S_IDLE))
		else $error("packet finished without an active row");

	// A bin picked for a flush beat must hold a nonzero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FL_EMIT) |-> (rsp.count != '0))
		else $error("flush beat built from an empty bin");

	// The beat marked last leaves the row empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && rsp.last) |=> rsp.empty)
		else $error("row not empty after the last flush beat");

	// The threshold scan never counts past the top gap bin.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (bin_idx_q <= IDX_W'(INTERVAL_BINS - 1)))
		else $error("gap bin count out of range");

endmodule

// File: hw/rtl/fsih_bin_store.sv
// Histogram row store: count memory with per-bin valid flags and saturating bump.
module fsih_bin_store (
	input  logic               clk,
	input  logic               arst_n,
	input  fsih_pkg::bin_req_t req,
	output fsih_pkg::bin_rsp_t rsp
);
	import fsih_pkg::*;

	logic [COUNT_W-1:0]    mem [TOTAL_BINS];
	logic [TOTAL_BINS-1:0] valid_q;
	logic [COUNT_W-1:0]    rd_data_q;
	logic                  rd_valid_q;
	logic                  rd_last_q;
	logic [TOTAL_BINS-1:0] addr_mask;
	logic [COUNT_W-1:0]    count_now;
	logic [COUNT_W-1:0]    count_inc;

	assign addr_mask = TOTAL_BINS'(1) << req.addr;

	// A bin that was never bumped since the last flush reads as zero.
	assign count_now = rd_valid_q ? rd_data_q : '0;
	assign count_inc = (&count_now) ? count_now : count_now + COUNT_W'(1);

	always_ff @(posedge clk) begin
		if (req.bump_en) mem[req.addr] <= count_inc;
		if (req.rd_en) rd_data_q <= mem[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_last_q  <= 1'b0;
		end else begin
			if (req.bump_en) valid_q[req.addr] <= 1'b1;
			else if (req.drop_en) valid_q[req.addr] <= 1'b0;
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.addr];
				rd_last_q  <= (valid_q & ~addr_mask) == '0;
			end
		end
	end

	assign rsp.count = count_now;
	assign rsp.last  = rd_last_q;
	assign rsp.hit   = valid_q[req.addr];
	assign rsp.empty = (valid_q == '0);

endmodule
